/* rtl/core/rsfp_pkg.sv */
// shared types and constants for the request stream frame parser
package rsfp_pkg;

    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int ACNT_W  = 32;
    localparam int LEVEL_W = 4;
    localparam int ERR_W   = 2;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ELEM_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ARRAY_HDR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    localparam logic [ERR_W-1:0] ERR_BAD_NUMBER = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_DEEP = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LARGE = 2'd2;

    localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [ACNT_W-1:0]  array_count;
        logic [LEVEL_W-1:0] levels_closed;
        logic               message_done;
        logic [ERR_W-1:0]   error_code;
    } result_t;

endpackage

/* rtl/core/rsfp_in_if.sv */
// byte stream channel into the parser
interface rsfp_in_if import rsfp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

/* rtl/core/rsfp_out_if.sv */
// result channel out of the parser
interface rsfp_out_if import rsfp_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [ACNT_W-1:0]  array_count;
    logic [LEVEL_W-1:0] levels_closed;
    logic               message_done;
    logic [ERR_W-1:0]   error_code;

    modport source (output valid, output kind, output byte_value, output array_count,
                    output levels_closed, output message_done, output error_code,
                    input ready);
    modport sink (input valid, input kind, input byte_value, input array_count,
                  input levels_closed, input message_done, input error_code,
                  output ready);
endinterface

/* rtl/core/resp_stream_frame_parser.sv */
// request stream deframer: parse state, nesting stack and result queue
// latency: a byte's first result, if any, is written to the result queue and valid in the cycle after the byte's beat
// throughput: one byte per cycle while the result queue has room; a byte with two results needs two output beats
// the four-entry result queue takes a byte only while two slots are free
// reset: asynchronous active low, parser returns to idle with no arrays open
// and the result queue empty; stack entries are not cleared
module resp_stream_frame_parser
    import rsfp_pkg::*;
#(
    parameter int MAX_DEPTH  = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    rsfp_in_if.sink          bytes,
    rsfp_out_if.source       results
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = COUNT_BITS;
    localparam int WW = COUNT_BITS + 4;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_SIMPLE = 3'd1;
    localparam logic [2:0] MODE_BLEN = 3'd2;
    localparam logic [2:0] MODE_BDATA = 3'd3;
    localparam logic [2:0] MODE_TRAIL = 3'd4;
    localparam logic [2:0] MODE_ACOUNT = 3'd5;

    localparam logic [1:0] NF_NONE = 2'd0;
    localparam logic [1:0] NF_OK = 2'd1;
    localparam logic [1:0] NF_BAD = 2'd2;
    localparam logic [1:0] NF_BIG = 2'd3;

    // parser state
    logic [2:0]    mode_reg, mode_next;
    logic          cr_reg, cr_next;
    logic [CW-1:0] num_reg, num_next;
    logic [1:0]    flags_reg, flags_next;
    logic [CW-1:0] bulk_reg, bulk_next;
    logic [1:0]    trail_reg, trail_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [CW-1:0] stack_reg [MAX_DEPTH];

    // result queue
    result_t       fifo_reg [4];
    logic [1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [2:0]    fill_reg;

    logic [BYTE_W-1:0] c;
    logic              accept;
    logic              pop;

    // element end over the open arrays
    logic [DW-1:0] lv_cnt;
    logic          ee_done;
    logic [DW-1:0] ee_target;
    logic [CW-1:0] ee_dec;
    result_t       ee_res;

    // number digit accumulation
    logic          is_digit;
    logic [WW-1:0] num_wide;
    logic          num_big;

    // step outputs
    logic          do_ee;
    logic          push_en;
    logic [1:0]    n_res;
    result_t       r0, r1;
    logic          stk_we;
    logic [IW-1:0] stk_idx;
    logic [CW-1:0] stk_data;

    assign c = bytes.in_byte;
    assign bytes.ready = (fill_reg <= 3'd2);
    assign accept = bytes.valid && bytes.ready;
    assign pop = results.valid && results.ready;

    always_comb
    begin
        logic above;
        logic live;
        above = 1'b1;
        lv_cnt = '0;
        for (int i = MAX_DEPTH - 1; i >= 0; i--)
        begin
            live = (DW'(i) < depth_reg);
            above = above && (!live || (stack_reg[i] == CW'(1)));
            if (live && above)
            begin
                lv_cnt = lv_cnt + DW'(1);
            end
        end
        ee_done = above;
        ee_target = depth_reg - DW'(1) - lv_cnt;
        ee_dec = stack_reg[ee_target[IW-1:0]] - CW'(1);
        ee_res = '0;
        ee_res.kind = KIND_ELEM_END;
        ee_res.levels_closed = LEVEL_W'(lv_cnt);
        ee_res.message_done = ee_done;
    end

    always_comb
    begin
        is_digit = (c inside {[CH_ZERO:CH_NINE]});
        num_wide = ({4'b0, num_reg} << 3) + ({4'b0, num_reg} << 1)
                 + WW'(c - CH_ZERO);
        num_big = (num_wide[WW-1:CW] != '0);
    end

    always_comb
    begin
        mode_next = mode_reg;
        cr_next = cr_reg;
        num_next = num_reg;
        flags_next = flags_reg;
        bulk_next = bulk_reg;
        trail_next = trail_reg;
        depth_next = depth_reg;
        do_ee = 1'b0;
        push_en = 1'b0;
        n_res = 2'd0;
        r0 = '0;
        r1 = '0;
        case (mode_reg)
            MODE_SIMPLE:
            begin
                if (cr_reg)
                begin
                    if (c == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                        cr_next = 1'b0;
                        do_ee = 1'b1;
                        r0 = ee_res;
                        n_res = 2'd1;
                    end
                    else
                    begin
                        r0.kind = KIND_PAYLOAD;
                        r0.byte_value = CH_CR;
                        if (c == CH_CR)
                        begin
                            n_res = 2'd1;
                        end
                        else
                        begin
                            cr_next = 1'b0;
                            r1.kind = KIND_PAYLOAD;
                            r1.byte_value = c;
                            n_res = 2'd2;
                        end
                    end
                end
                else if (c == CH_CR)
                begin
                    cr_next = 1'b1;
                end
                else
                begin
                    r0.kind = KIND_PAYLOAD;
                    r0.byte_value = c;
                    n_res = 2'd1;
                end
            end
            MODE_BLEN, MODE_ACOUNT:
            begin
                if (cr_reg && (c == CH_LF))
                begin
                    if (flags_reg == NF_BIG || flags_reg != NF_OK)
                    begin
                        r0.kind = KIND_ERROR;
                        r0.error_code = (flags_reg == NF_BIG) ? ERR_TOO_LARGE
                                                               : ERR_BAD_NUMBER;
                        n_res = 2'd1;
                        depth_next = '0;
                        mode_next = MODE_IDLE;
                        cr_next = 1'b0;
                    end
                    else if (mode_reg == MODE_BLEN)
                    begin
                        cr_next = 1'b0;
                        bulk_next = num_reg;
                        if (num_reg == '0)
                        begin
                            mode_next = MODE_TRAIL;
                            trail_next = 2'd2;
                        end
                        else
                        begin
                            mode_next = MODE_BDATA;
                        end
                    end
                    else if (depth_reg >= DW'(MAX_DEPTH))
                    begin
                        r0.kind = KIND_ERROR;
                        r0.error_code = ERR_TOO_DEEP;
                        n_res = 2'd1;
                        depth_next = '0;
                        mode_next = MODE_IDLE;
                        cr_next = 1'b0;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        cr_next = 1'b0;
                        r0.kind = KIND_ARRAY_HDR;
                        r0.array_count = ACNT_W'(num_reg);
                        if (num_reg == '0)
                        begin
                            do_ee = 1'b1;
                            r1 = ee_res;
                            n_res = 2'd2;
                        end
                        else
                        begin
                            push_en = 1'b1;
                            depth_next = depth_reg + DW'(1);
                            n_res = 2'd1;
                        end
                    end
                end
                else if (cr_reg)
                begin
                    flags_next = NF_BAD;
                    if (c != CH_CR)
                    begin
                        cr_next = 1'b0;
                    end
                end
                else if (c == CH_CR)
                begin
                    cr_next = 1'b1;
                end
                else if (is_digit)
                begin
                    if (flags_reg == NF_NONE || flags_reg == NF_OK)
                    begin
                        if (num_big)
                        begin
                            flags_next = NF_BIG;
                        end
                        else
                        begin
                            num_next = num_wide[CW-1:0];
                            flags_next = NF_OK;
                        end
                    end
                end
                else
                begin
                    flags_next = NF_BAD;
                end
            end
            MODE_BDATA:
            begin
                r0.kind = KIND_PAYLOAD;
                r0.byte_value = c;
                n_res = 2'd1;
                bulk_next = bulk_reg - CW'(1);
                if (bulk_reg == CW'(1))
                begin
                    mode_next = MODE_TRAIL;
                    trail_next = 2'd2;
                end
            end
            MODE_TRAIL:
            begin
                if (trail_reg > 2'd1)
                begin
                    trail_next = trail_reg - 2'd1;
                end
                else
                begin
                    trail_next = 2'd0;
                    mode_next = MODE_IDLE;
                    cr_next = 1'b0;
                    do_ee = 1'b1;
                    r0 = ee_res;
                    n_res = 2'd1;
                end
            end
            default:
            begin
                cr_next = 1'b0;
                num_next = '0;
                flags_next = NF_NONE;
                if (c == CH_PLUS)
                begin
                    mode_next = MODE_SIMPLE;
                end
                else if (c == CH_DOLLAR)
                begin
                    mode_next = MODE_BLEN;
                end
                else if (c == CH_STAR)
                begin
                    mode_next = MODE_ACOUNT;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
        endcase
        // element end pops filled arrays and counts down the next one; a non-empty array header pushes its count
        stk_we = 1'b0;
        stk_idx = depth_reg[IW-1:0];
        stk_data = num_reg;
        if (do_ee)
        begin
            if (ee_done)
            begin
                depth_next = '0;
            end
            else
            begin
                depth_next = ee_target + DW'(1);
                stk_we = 1'b1;
                stk_idx = ee_target[IW-1:0];
                stk_data = ee_dec;
            end
        end
        else if (push_en)
        begin
            stk_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cr_reg <= 1'b0;
            num_reg <= '0;
            flags_reg <= NF_NONE;
            bulk_reg <= '0;
            trail_reg <= 2'd0;
            depth_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cr_reg <= cr_next;
            num_reg <= num_next;
            flags_reg <= flags_next;
            bulk_reg <= bulk_next;
            trail_reg <= trail_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && stk_we)
        begin
            stack_reg[stk_idx] <= stk_data;
        end
    end

    // result queue, up to two writes and one read per cycle
    always_ff @(posedge clk)
    begin
        if (accept && (n_res != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= r0;
        end
        if (accept && (n_res == 2'd2))
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            fill_reg <= 3'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            fill_reg <= fill_reg + (accept ? {1'b0, n_res} : 3'd0)
                      - (pop ? 3'd1 : 3'd0);
        end
    end

    assign results.valid = (fill_reg != 3'd0);
    assign results.kind = fifo_reg[rd_ptr_reg].kind;
    assign results.byte_value = fifo_reg[rd_ptr_reg].byte_value;
    assign results.array_count = fifo_reg[rd_ptr_reg].array_count;
    assign results.levels_closed = fifo_reg[rd_ptr_reg].levels_closed;
    assign results.message_done = fifo_reg[rd_ptr_reg].message_done;
    assign results.error_code = fifo_reg[rd_ptr_reg].error_code;

endmodule
